// ===== sv/sbpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpm_pkg
// Shared constants, codes and types for the stream buffer pool manager.
// ----------------------------------------------------------------------------
package sbpm_pkg;

    // default pool shape
    localparam int DEF_BUFFER_COUNT = 4;
    localparam int DEF_BUFFER_BYTES = 512 * 1024;

    // fixed field widths
    localparam int REQ_W     = 2;
    localparam int BYTES_W   = 20;
    localparam int ACT_W     = 2;
    localparam int OUT_IDX_W = 2;
    localparam int OUT_CNT_W = 3;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 56;
    localparam int M_FIELD_W = ACT_W + 2 * OUT_IDX_W + 2 * BYTES_W + 1 + 2 * OUT_CNT_W + 1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_FILL   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAUSED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // download actions
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REBIND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PAUSE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESUME = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } sbpm_state_t;

    typedef struct packed {
        logic load;     // capture request beat
        logic commit;   // apply request, load result register
    } sbpm_cmd_t;

    typedef struct packed {
        logic out_busy; // result register holds a beat that is not taken
    } sbpm_status_t;

endpackage
`default_nettype wire

// ===== sv/sbpm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpm_ctrl
// Two-state sequencer: latch a request, then commit it once the result
// register can take a new beat.
// ----------------------------------------------------------------------------
module sbpm_ctrl
    import sbpm_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_tvalid,
    output logic        s_tready,
    input  sbpm_status_t status,
    output sbpm_cmd_t   cmd
);

    sbpm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/sbpm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpm_datapath
// Free and full index queues, download/read bookkeeping, grant arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module sbpm_datapath
    import sbpm_pkg::*;
#(
    parameter int BUFFER_COUNT = DEF_BUFFER_COUNT,
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  sbpm_cmd_t              cmd,
    output sbpm_status_t           status,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [BYTES_W-1:0] want_bytes,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int SLOT_COUNT = BUFFER_COUNT + 1;
    localparam int IDX_W      = $clog2(BUFFER_COUNT);
    localparam int PTR_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(BUFFER_COUNT + 1);
    localparam int POS_W      = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W      = (POS_W > BYTES_W) ? POS_W : BYTES_W;

    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUFFER_COUNT);
    localparam logic [CNT_W-1:0] CNT_ALMOST = CNT_W'(BUFFER_COUNT - 1);
    localparam logic [CMP_W-1:0] BYTES_CMP = CMP_W'(BUFFER_BYTES);
    localparam logic [POS_W-1:0] BYTES_POS = POS_W'(BUFFER_BYTES);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // queue state
    logic [IDX_W-1:0] free_slots_reg [SLOT_COUNT];
    logic [IDX_W-1:0] full_slots_reg [SLOT_COUNT];
    logic [PTR_W-1:0] free_head_reg, free_head_next, free_tail_reg, free_tail_next;
    logic [PTR_W-1:0] full_head_reg, full_head_next, full_tail_reg, full_tail_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next, full_cnt_reg, full_cnt_next;

    // download / reader state
    logic [IDX_W-1:0] dl_idx_reg, dl_idx_next;
    logic             rd_open_reg, rd_open_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [POS_W-1:0] rd_pos_reg, rd_pos_next;

    // request and result registers
    logic [REQ_W-1:0]   req_type_reg;
    logic [BYTES_W-1:0] wanted_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // step decision
    logic             free_push, full_push;
    logic [IDX_W-1:0] rd_idx_sel;
    logic [POS_W-1:0] rd_pos_sel;
    logic [CMP_W-1:0] avail, wanted_ext, grant;
    logic             use_up;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] rbuf;
    logic [POS_W-1:0] roff;
    logic [CMP_W-1:0] ncopy;
    logic             released, err;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= req_type;
            wanted_reg   <= want_bytes;
        end
    end

    always_comb begin
        rd_idx_sel = rd_open_reg ? rd_idx_reg : full_slots_reg[full_tail_reg];
        rd_pos_sel = rd_open_reg ? rd_pos_reg : '0;
        avail      = BYTES_CMP - CMP_W'(rd_pos_sel);
        wanted_ext = CMP_W'(wanted_reg);
        use_up     = (wanted_ext >= avail);
        grant      = use_up ? avail : wanted_ext;
    end

    always_comb begin
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        free_cnt_next  = free_cnt_reg;
        full_head_next = full_head_reg;
        full_tail_next = full_tail_reg;
        full_cnt_next  = full_cnt_reg;
        dl_idx_next    = dl_idx_reg;
        rd_open_next   = rd_open_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pos_next    = rd_pos_reg;
        free_push      = 1'b0;
        full_push      = 1'b0;
        act            = ACT_NONE;
        rbuf           = '0;
        roff           = '0;
        ncopy          = '0;
        released       = 1'b0;
        err            = 1'b0;
        case (req_type_reg)
            REQ_FILL: begin
                if (full_cnt_reg == CNT_FULL) begin
                    err = 1'b1;
                end else begin
                    full_push      = 1'b1;
                    full_head_next = ptr_inc(full_head_reg);
                    full_cnt_next  = full_cnt_reg + CNT_W'(1);
                    if (full_cnt_reg == CNT_ALMOST || free_cnt_reg == '0) begin
                        act = ACT_PAUSE;
                    end else begin
                        dl_idx_next    = free_slots_reg[free_tail_reg];
                        free_tail_next = ptr_inc(free_tail_reg);
                        free_cnt_next  = free_cnt_reg - CNT_W'(1);
                        act            = ACT_REBIND;
                    end
                end
            end
            REQ_PAUSED: begin
                if (free_cnt_reg != '0) begin
                    dl_idx_next    = free_slots_reg[free_tail_reg];
                    free_tail_next = ptr_inc(free_tail_reg);
                    free_cnt_next  = free_cnt_reg - CNT_W'(1);
                    act            = ACT_RESUME;
                end
            end
            REQ_READ: begin
                if (!rd_open_reg && full_cnt_reg == '0) begin
                    err = 1'b1;
                end else if (use_up && free_cnt_reg == CNT_FULL) begin
                    // release would overflow the free queue
                    err = 1'b1;
                end else begin
                    if (!rd_open_reg) begin
                        full_tail_next = ptr_inc(full_tail_reg);
                        full_cnt_next  = full_cnt_reg - CNT_W'(1);
                    end
                    rbuf  = rd_idx_sel;
                    roff  = rd_pos_sel;
                    ncopy = grant;
                    if (use_up) begin
                        free_push      = 1'b1;
                        free_head_next = ptr_inc(free_head_reg);
                        free_cnt_next  = free_cnt_reg + CNT_W'(1);
                        released       = 1'b1;
                        rd_open_next   = 1'b0;
                        rd_idx_next    = '0;
                        rd_pos_next    = '0;
                    end else begin
                        rd_open_next = 1'b1;
                        rd_idx_next  = rd_idx_sel;
                        rd_pos_next  = rd_pos_sel + POS_W'(grant);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result beat, fields from bit 0 up
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[M_FIELD_W-1:0] = {
            err,
            OUT_CNT_W'(free_cnt_next),
            OUT_CNT_W'(full_cnt_next),
            released,
            BYTES_W'(ncopy),
            BYTES_W'(roff),
            OUT_IDX_W'(rbuf),
            OUT_IDX_W'(dl_idx_next),
            act
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                free_slots_reg[i] <= (i < BUFFER_COUNT) ? IDX_W'(i) : '0;
            end
            // buffer 0 already handed to the download
            free_head_reg <= PTR_W'(BUFFER_COUNT);
            free_tail_reg <= PTR_W'(1);
            free_cnt_reg  <= CNT_ALMOST;
            full_head_reg <= '0;
            full_tail_reg <= '0;
            full_cnt_reg  <= '0;
            dl_idx_reg    <= '0;
            rd_open_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rd_pos_reg    <= '0;
        end else if (cmd.commit) begin
            if (free_push) begin
                free_slots_reg[free_head_reg] <= rd_idx_sel;
            end
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            free_cnt_reg  <= free_cnt_next;
            full_head_reg <= full_head_next;
            full_tail_reg <= full_tail_next;
            full_cnt_reg  <= full_cnt_next;
            dl_idx_reg    <= dl_idx_next;
            rd_open_reg   <= rd_open_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pos_reg    <= rd_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && full_push) begin
            full_slots_reg[full_head_reg] <= dl_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_cnt_reg <= CNT_FULL) && (full_cnt_reg <= CNT_FULL))
        else $error("queue count out of range");

    a_err_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && err |=> (free_cnt_reg == $past(free_cnt_reg))
            && (full_cnt_reg == $past(full_cnt_reg))
            && (dl_idx_reg == $past(dl_idx_reg))
            && (rd_open_reg == $past(rd_open_reg)))
        else $error("errored step changed state");

    a_closed_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !rd_open_reg |-> (rd_pos_reg == '0))
        else $error("read position set with no open buffer");

    a_open_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_open_reg |-> (rd_pos_reg < BYTES_POS))
        else $error("open buffer already used up");
`endif

endmodule
`default_nettype wire

// ===== sv/stream_buffer_pool_manager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stream_buffer_pool_manager
// Recycles a fixed pool of stream buffers between a downloader and a reader
// through free and full index queues.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                      | tuser
//  s_       | in  | want_bytes                 | req_type
//  m_       | out | action, buffers, grant,    | -
//           |     | counts, error              |
//
//  Each event first registers the request beat, then updates the queues and
//  loads the result register.
//  A new request is taken while the previous result waits on m_tready; its
//  update step stalls only until that result is taken.
//  After reset the free queue holds buffers 1..N-1 and the download owns
//  buffer 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stream_buffer_pool_manager
    import sbpm_pkg::*;
#(
    parameter int BUFFER_COUNT = DEF_BUFFER_COUNT,
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [19:0] want_bytes
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // [1:0] req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] download_action, [3:2] download_buffer, [5:4] read_buffer,
    // [25:6] read_offset, [45:26] copy_bytes, [46] buffer_released,
    // [49:47] full_count, [52:50] free_count, [53] queue_error
    output logic [M_TDATA_W-1:0]      m_tdata
);

    sbpm_cmd_t    cmd;
    sbpm_status_t status;

    sbpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbpm_datapath #(
        .BUFFER_COUNT (BUFFER_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .req_type     (s_tuser),
        .want_bytes   (s_tdata[BYTES_W-1:0]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

endmodule
`default_nettype wire

// ===== bench/stream_buffer_pool_manager_test.sv =====
// ----------------------------------------------------------------------------
// stream_buffer_pool_manager_test
// Self-checking bench for the buffer pool manager. A directed opening walks the
// queues through underflow, overflow, pause and release corners, then three
// random phases vary sender gaps and receiver stalls. One phase holds the
// receiver off long enough to back up the input. Every result beat is checked
// against an in-bench model of the free and full index queues.
// ----------------------------------------------------------------------------
module stream_buffer_pool_manager_test;
    import sbpm_pkg::*;

    localparam int SLOTS = DEF_BUFFER_COUNT + 1;
    localparam int unsigned BUF_BYTES = DEF_BUFFER_BYTES;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [BYTES_W-1:0] wanted;
    } pool_req_t;

    // same bit order as the result tdata, lowest field last
    typedef struct packed {
        logic                 err;
        logic [OUT_CNT_W-1:0] free_cnt;
        logic [OUT_CNT_W-1:0] full_cnt;
        logic                 released;
        logic [BYTES_W-1:0]   copy;
        logic [BYTES_W-1:0]   rd_off;
        logic [OUT_IDX_W-1:0] rd_buf;
        logic [OUT_IDX_W-1:0] dl_buf;
        logic [ACT_W-1:0]     action;
    } pool_grant_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    stream_buffer_pool_manager uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // pool state as it stands after reset: download owns buffer 0
    logic [OUT_IDX_W-1:0] free_ring [SLOTS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
    logic [OUT_IDX_W-1:0] full_ring [SLOTS] = '{default: '0};
    int                   free_wr = 4;
    int                   free_rd = 1;
    int                   full_wr = 0;
    int                   full_rd = 0;
    logic [OUT_IDX_W-1:0] dl_buf = '0;
    logic                 rd_open = 1'b0;
    logic [OUT_IDX_W-1:0] rd_buf = '0;
    int unsigned          rd_pos = 0;

    pool_req_t   req_backlog[$];
    pool_grant_t grants_due[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    logic        req_taken = 1'b0;

    function automatic int ring_next(int i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    function automatic int ring_fill(int wr, int rd);
        return (wr >= rd) ? wr - rd : wr + SLOTS - rd;
    endfunction

    // advances the pool state by one event and returns the grant it produces
    function automatic pool_grant_t predict_grant(pool_req_t r);
        pool_grant_t          g;
        logic                 take;
        logic [OUT_IDX_W-1:0] idx;
        int unsigned          pos;
        int unsigned          avail;
        int unsigned          ncopy;
        g = '0;
        case (r.kind)
            REQ_FILL: begin
                if (ring_next(full_wr) == full_rd) begin
                    g.err = 1'b1;
                end else begin
                    full_ring[full_wr] = dl_buf;
                    full_wr = ring_next(full_wr);
                    if (ring_next(full_wr) == full_rd || free_wr == free_rd) begin
                        g.action = ACT_PAUSE;
                    end else begin
                        dl_buf = free_ring[free_rd];
                        free_rd = ring_next(free_rd);
                        g.action = ACT_REBIND;
                    end
                end
            end
            REQ_PAUSED: begin
                if (free_wr != free_rd) begin
                    dl_buf = free_ring[free_rd];
                    free_rd = ring_next(free_rd);
                    g.action = ACT_RESUME;
                end
            end
            REQ_READ: begin
                if (!rd_open && full_wr == full_rd) begin
                    g.err = 1'b1;
                end else begin
                    take = !rd_open;
                    idx = take ? full_ring[full_rd] : rd_buf;
                    pos = take ? 0 : rd_pos;
                    avail = (pos < BUF_BYTES) ? BUF_BYTES - pos : 0;
                    ncopy = (r.wanted < avail) ? r.wanted : avail;
                    // a release into a full free queue is refused whole
                    if (pos + ncopy == BUF_BYTES && ring_next(free_wr) == free_rd) begin
                        g.err = 1'b1;
                    end else begin
                        if (take)
                            full_rd = ring_next(full_rd);
                        g.rd_buf = idx;
                        g.rd_off = BYTES_W'(pos);
                        g.copy = BYTES_W'(ncopy);
                        pos += ncopy;
                        if (pos == BUF_BYTES) begin
                            free_ring[free_wr] = idx;
                            free_wr = ring_next(free_wr);
                            g.released = 1'b1;
                            rd_open = 1'b0;
                            rd_buf = '0;
                            rd_pos = 0;
                        end else begin
                            rd_open = 1'b1;
                            rd_buf = idx;
                            rd_pos = pos;
                        end
                    end
                end
            end
            default: ;
        endcase
        g.dl_buf = dl_buf;
        g.full_cnt = OUT_CNT_W'(ring_fill(full_wr, full_rd));
        g.free_cnt = OUT_CNT_W'(ring_fill(free_wr, free_rd));
        return g;
    endfunction

    function automatic string grant_text(pool_grant_t g);
        return $sformatf("act=%0d dl=%0d rb=%0d off=%0d n=%0d rel=%0d full=%0d free=%0d err=%0d",
                         g.action, g.dl_buf, g.rd_buf, g.rd_off, g.copy, g.released,
                         g.full_cnt, g.free_cnt, g.err);
    endfunction

    // request driver
    always @(negedge aclk) begin
        pool_req_t nxt;
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = req_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.kind;
                s_tdata  <= {{(S_TDATA_W - BYTES_W){1'b0}}, nxt.wanted};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    int holds_started = 0;
    int hold_left = 0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: check result beats, then predict for the request beat
    always @(posedge aclk) begin
        pool_grant_t got;
        pool_grant_t want;
        req_taken = aresetn && s_tvalid && s_tready;
        got = m_tdata[M_FIELD_W-1:0];
        if (aresetn && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: %s", $time, grant_text(got));
            end else begin
                want = grants_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: mismatch: expected %s", $time, grant_text(want));
                    $display("%0t:           actual   %s", $time, grant_text(got));
                end
            end
        end
        if (req_taken)
            grants_due.push_back(predict_grant('{kind: s_tuser, wanted: s_tdata[BYTES_W-1:0]}));
    end

    // watchdog on cycles without any beat
    int stalled = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled = 0;
        else
            stalled = stalled + 1;
        if (stalled == STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("stream_buffer_pool_manager_test failed");
            $finish;
        end
    end

    task automatic queue_req(logic [REQ_W-1:0] kind, logic [BYTES_W-1:0] wanted);
        req_backlog.push_back('{kind, wanted});
    endtask

    task automatic wait_sent();
        while (req_backlog.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic run_phase(int count, int send_pct, int recv_pct, bit squeeze);
        int unsigned      pick;
        int               fill_pct;
        logic [REQ_W-1:0] kind;
        logic [BYTES_W-1:0] wanted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (squeeze)
            hold_requests++;
        for (int i = 0; i < count; i++) begin
            // alternate fill-heavy and read-heavy bursts to swing the queues
            fill_pct = ((i / 40) % 2) ? 50 : 20;
            pick = $urandom_range(0, 99);
            if (pick < fill_pct)
                kind = REQ_FILL;
            else if (pick < fill_pct + 12)
                kind = REQ_PAUSED;
            else if (pick < 95)
                kind = REQ_READ;
            else
                kind = REQ_UNKNOWN;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                wanted = '0;
            else if (pick < 20)
                wanted = BYTES_W'(DEF_BUFFER_BYTES);
            else if (pick < 35)
                wanted = BYTES_W'($urandom_range(0, 1023));
            else if (pick < 50)
                wanted = BYTES_W'($urandom);
            else
                wanted = BYTES_W'($urandom_range(0, DEF_BUFFER_BYTES));
            queue_req(kind, wanted);
        end
        wait_sent();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 54;
        queue_req(REQ_READ, 20'h80000);    // nothing full yet: underflow
        queue_req(REQ_UNKNOWN, 20'hFFFFF);
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_READ, 20'h00000);    // opens a buffer, grants nothing
        queue_req(REQ_READ, 20'h7FFFF);
        queue_req(REQ_READ, 20'hFFFFF);    // last byte, buffer released
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_FILL, 20'h00000);    // full queue fills up: pause
        queue_req(REQ_FILL, 20'hFFFFF);    // full queue overflow
        queue_req(REQ_PAUSED, 20'h00000);  // no free buffer: no action
        queue_req(REQ_READ, 20'h00001);
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_READ, 20'hFFFFF);
        queue_req(REQ_READ, 20'h80000);
        queue_req(REQ_READ, 20'h80000);
        queue_req(REQ_READ, 20'h80000);    // free queue now holds every buffer
        queue_req(REQ_READ, 20'h80000);    // release would overflow free queue
        queue_req(REQ_READ, 20'h40000);
        queue_req(REQ_PAUSED, 20'h00000);
        queue_req(REQ_READ, 20'h40000);
        queue_req(REQ_READ, 20'hAAAAA);
        queue_req(REQ_FILL, 20'h00000);
        queue_req(REQ_READ, 20'h55555);
        wait_sent();

        run_phase(570, 14, 54, 1'b0);
        run_phase(570, 54, 14, 1'b0);
        run_phase(560, 0, 0, 1'b1);

        while (grants_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("stream_buffer_pool_manager_test passed");
        else
            $display("stream_buffer_pool_manager_test failed");
        $finish;
    end

endmodule
